FILE: hdl/bounded_array_shift_engine_macros.svh
// Assertion macros shared by the array shift engine RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef BOUNDED_ARRAY_SHIFT_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_SHIFT_ENGINE_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define BASE_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed: invariant");

// When the trigger holds, the consequence holds at the next clock edge.
`define BASE_ASSERT_NEXT(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");

// When the trigger holds, the consequence holds at the same clock edge.
`define BASE_ASSERT_SAME(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error("assertion failed: same-cycle rule");

`endif

FILE: hdl/base_pkg.sv
// Package for the array shift engine: sizes, command and status codes,
// and the control bundle broadcast to the slot cells. No dependencies.
package base_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 8;
	localparam int WORD_W   = 64;
	localparam int STAT_W   = 3;
	localparam int COUNT_W  = 7;
	// Comparison width: holds any position and any count, plus one spare bit.
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_PUSH   = 3'd2,
		OP_POP    = 3'd3,
		OP_INSERT = 3'd4,
		OP_ERASE  = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_RESIZE = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_INDEX = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_BAD_SIZE  = 3'd4
	} status_t;

	typedef struct packed {
		logic              act;
		op_t               op;
		logic [CMP_W-1:0]  pos;
		logic [CMP_W-1:0]  cnt;
		logic [CMP_W-1:0]  cnt_m1;
		logic [WORD_W-1:0] word;
	} ctl_t;

endpackage

FILE: hdl/base_cmd_if.sv
// Command channel of the array shift engine: valid/ready plus the command item.
// Depends on base_pkg for field widths.
interface base_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    command;
	logic [base_pkg::POS_W-1:0]    position;
	logic [base_pkg::WORD_W-1:0]   word_in;

	modport source (output valid, command, position, word_in, input ready);
	modport sink   (input valid, command, position, word_in, output ready);
endinterface

FILE: hdl/base_rsp_if.sv
// Response channel of the array shift engine: valid/ready plus the result item.
// Depends on base_pkg for field widths.
interface base_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [base_pkg::WORD_W-1:0]   word_out;
	logic [base_pkg::STAT_W-1:0]   status;
	logic [base_pkg::COUNT_W-1:0]  count;

	modport source (output valid, word_out, status, count, input ready);
	modport sink   (input valid, word_out, status, count, output ready);
endinterface

FILE: hdl/bounded_array_shift_engine.sv
// Top level of the array shift engine: a row of slot cells, the live count,
// command checking and the response register. Depends on base_pkg, base_cell,
// base_cmd_if, base_rsp_if and the assertion macro header.
//
//   channel | role   | payload                         | transfer when
//   cmd     | sink   | command, position, word_in      | cmd.valid && cmd.ready
//   rsp     | source | word_out, status, count         | rsp.valid && rsp.ready
//
// Every command, insert and erase included, completes in the cycle in which it
// is transferred: the whole row of cells shifts by one slot together.
// The response appears in the output register in the cycle after, so one command
// per cycle is sustained while the response side keeps up.
// Reset clears every slot to zero and the live count to zero at once.
// A stalled response holds the command side off only while the output
// register is full and not being taken.
`include "bounded_array_shift_engine_macros.svh"

module bounded_array_shift_engine (
	input  logic      clk,
	input  logic      arst_n,
	base_cmd_if.sink  cmd,
	base_rsp_if.source rsp
);

	localparam int CAP  = base_pkg::CAPACITY;
	localparam int CW   = base_pkg::CMP_W;

	// Live count and the response register.
	logic [base_pkg::CNT_W-1:0]   count_q;
	logic [base_pkg::CNT_W-1:0]   count_d;
	logic                         rsp_valid_q;
	logic [base_pkg::WORD_W-1:0]  rsp_word_q;
	base_pkg::status_t            rsp_status_q;
	logic [base_pkg::COUNT_W-1:0] rsp_count_q;

	logic                         accept;
	base_pkg::op_t                op;
	base_pkg::status_t            status;
	logic [CW-1:0]                pos_e;
	logic [CW-1:0]                cnt_e;
	logic [CW-1:0]                cap_e;
	logic                         idx_bad;
	base_pkg::ctl_t               ctl;
	logic [base_pkg::WORD_W-1:0]  rd_word;
	logic [base_pkg::CNT_W+base_pkg::COUNT_W-1:0] count_ext;

	// Slot words and per-cell read contributions, one entry per cell.
	logic [base_pkg::WORD_W-1:0]  slot_w [CAP];
	logic [base_pkg::WORD_W-1:0]  rd_w   [CAP];

	// The command side is free whenever the response register is empty or is
	// being emptied in this very cycle.
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign op      = base_pkg::op_t'(cmd.command);
	assign pos_e   = CW'(cmd.position);
	assign cnt_e   = CW'(count_q);
	assign cap_e   = CW'(CAP);
	// The count never exceeds the capacity, so an index below the count is
	// also below the capacity.
	assign idx_bad = (pos_e >= cnt_e);

	// Status check and next count. A failing command leaves the count alone.
	always_comb begin
		status  = base_pkg::ST_OK;
		count_d = count_q;
		case (op)
			base_pkg::OP_READ, base_pkg::OP_WRITE, base_pkg::OP_ERASE: begin
				if (idx_bad) begin
					status = base_pkg::ST_BAD_INDEX;
				end else if (op == base_pkg::OP_ERASE) begin
					count_d = count_q - 1'b1;
				end
			end
			base_pkg::OP_PUSH: begin
				if (cnt_e >= cap_e) status = base_pkg::ST_FULL;
				else count_d = count_q + 1'b1;
			end
			base_pkg::OP_POP: begin
				if (count_q == '0) status = base_pkg::ST_EMPTY;
				else count_d = count_q - 1'b1;
			end
			base_pkg::OP_INSERT: begin
				// The index check takes precedence over the full check.
				if (idx_bad) status = base_pkg::ST_BAD_INDEX;
				else if (cnt_e >= cap_e) status = base_pkg::ST_FULL;
				else count_d = count_q + 1'b1;
			end
			base_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			base_pkg::OP_RESIZE: begin
				// Growing exposes whatever the slots above the old count hold.
				if (pos_e > cap_e) status = base_pkg::ST_BAD_SIZE;
				else count_d = base_pkg::CNT_W'(pos_e);
			end
			default: begin
			end
		endcase
	end

	// Control broadcast to every cell; cells act only on a successful transfer.
	always_comb begin
		ctl.act    = accept && (status == base_pkg::ST_OK);
		ctl.op     = op;
		ctl.pos    = pos_e;
		ctl.cnt    = cnt_e;
		ctl.cnt_m1 = cnt_e - 1'b1;
		ctl.word   = cmd.word_in;
	end

	// The row of cells. Each cell sees its lower and upper neighbour; the ends
	// of the row see zero, which no shift ever selects there.
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		logic [base_pkg::WORD_W-1:0] left_w;
		logic [base_pkg::WORD_W-1:0] right_w;

		if (g == 0) begin : g_lo
			assign left_w = '0;
		end else begin : g_lo
			assign left_w = slot_w[g-1];
		end

		if (g == CAP - 1) begin : g_hi
			assign right_w = '0;
		end else begin : g_hi
			assign right_w = slot_w[g+1];
		end

		base_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (base_pkg::IDX_W'(g)),
			.ctl    (ctl),
			.left   (left_w),
			.right  (right_w),
			.slot   (slot_w[g]),
			.rd     (rd_w[g])
		);
	end

	// At most one cell drives a non-zero read word, so an OR gathers it.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAP; i++) begin
			rd_word = rd_word | rd_w[i];
		end
	end

	// The reported count is the updated count after the command, in seven bits.
	assign count_ext = {{base_pkg::COUNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_word_q   <= '0;
			rsp_status_q <= base_pkg::ST_OK;
			rsp_count_q  <= '0;
		end else begin
			if (accept) begin
				count_q      <= count_d;
				rsp_valid_q  <= 1'b1;
				rsp_word_q   <= rd_word;
				rsp_status_q <= status;
				rsp_count_q  <= count_ext[base_pkg::COUNT_W-1:0];
			end else if (rsp.ready) begin
				rsp_valid_q  <= 1'b0;
			end
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.word_out = rsp_word_q;
	assign rsp.status   = rsp_status_q;
	assign rsp.count    = rsp_count_q;

	// The live count never passes the capacity.
	`BASE_ASSERT_ALWAYS(a_count_bound, count_q <= base_pkg::CNT_W'(CAP))
	// Only a successful read returns a non-zero word.
	`BASE_ASSERT_SAME(a_word_ok, rsp_valid_q && (rsp_word_q != '0), rsp_status_q == base_pkg::ST_OK)
	// A successful push adds exactly one element.
	`BASE_ASSERT_NEXT(a_push_count, accept && (op == base_pkg::OP_PUSH) && (status == base_pkg::ST_OK), count_q == $past(count_q) + 1'b1)
	// A failing command leaves the count as it was.
	`BASE_ASSERT_NEXT(a_fail_hold, accept && (status != base_pkg::ST_OK), count_q == $past(count_q))
	// A response that waits blocks further commands.
	`BASE_ASSERT_SAME(a_stall_block, rsp_valid_q && !rsp.ready, !cmd.ready)

endmodule

FILE: hdl/base_cell.sv
// One slot cell of the array shift engine: holds a word and updates it from
// the broadcast control and its two neighbours. Depends on base_pkg.
module base_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [base_pkg::IDX_W-1:0]   idx,
	input  base_pkg::ctl_t               ctl,
	input  logic [base_pkg::WORD_W-1:0]  left,
	input  logic [base_pkg::WORD_W-1:0]  right,
	output logic [base_pkg::WORD_W-1:0]  slot,
	output logic [base_pkg::WORD_W-1:0]  rd
);

	logic [base_pkg::WORD_W-1:0] slot_q;
	logic [base_pkg::WORD_W-1:0] slot_d;
	logic [base_pkg::CMP_W-1:0]  here;

	assign here = base_pkg::CMP_W'(idx);
	assign slot = slot_q;

	always_comb begin
		slot_d = slot_q;
		rd     = '0;
		if (ctl.act) begin
			case (ctl.op)
				base_pkg::OP_READ: begin
					if (here == ctl.pos) rd = slot_q;
				end
				base_pkg::OP_WRITE: begin
					if (here == ctl.pos) slot_d = ctl.word;
				end
				base_pkg::OP_PUSH: begin
					if (here == ctl.cnt) slot_d = ctl.word;
				end
				base_pkg::OP_POP: begin
					if (here == ctl.cnt_m1) slot_d = '0;
				end
				base_pkg::OP_INSERT: begin
					if (here == ctl.pos) begin
						slot_d = ctl.word;
					end else if (here > ctl.pos && here <= ctl.cnt) begin
						slot_d = left;
					end
				end
				base_pkg::OP_ERASE: begin
					// The top live slot keeps its old word when something above
					// the erased index moves down into the gap.
					if (here >= ctl.pos && (here + 1'b1) < ctl.cnt) begin
						slot_d = right;
					end else if (here == ctl.pos) begin
						slot_d = '0;
					end
				end
				base_pkg::OP_CLEAR: begin
					if (here < ctl.cnt) slot_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

endmodule
